### sv/dbwu_pkg.sv
// package for the debug breakpoint and watchpoint unit
// holds payload structs, op codes, result codes and the controller/datapath link types
// no dependencies
package dbwu_pkg;

    localparam int BP_SLOTS_DEF    = 64;
    localparam int WATCH_SLOTS_DEF = 16;

    localparam logic [7:0] SIG_TRAP = 8'd5;

    typedef enum logic [3:0] {
        OP_SET_BP      = 4'd0,
        OP_CLR_BP      = 4'd1,
        OP_SET_WATCH   = 4'd2,
        OP_CLR_WATCH   = 4'd3,
        OP_PC_CHECK    = 4'd4,
        OP_RD_CHECK    = 4'd5,
        OP_WR_CHECK    = 4'd6,
        OP_HALT        = 4'd7,
        OP_CONTINUE    = 4'd8,
        OP_STEP        = 4'd9,
        OP_EXCEPTION   = 4'd10,
        OP_CLEAR_ALL   = 4'd11
    } op_t;

    localparam logic [1:0] WK_WRITE  = 2'd0;
    localparam logic [1:0] WK_READ   = 2'd1;
    localparam logic [1:0] WK_ACCESS = 2'd2;

    localparam logic [2:0] SK_NONE   = 3'd0;
    localparam logic [2:0] SK_SIGNAL = 3'd1;
    localparam logic [2:0] SK_WATCH  = 3'd2;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] address;
        logic [31:0] length;
        logic [1:0]  watch_kind;
        logic [7:0]  signal_code;
    } item_t;

    typedef struct packed {
        logic        proceed;
        logic [1:0]  stop_notices;
        logic [7:0]  stop_signal;
        logic [2:0]  stop_kind;
        logic [63:0] watch_address;
        logic        table_full;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the item
        logic execute;  // apply the op and build the result
    } dp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

### sv/dbwu_datapath.sv
// datapath of the debug unit: breakpoint and watch tables, flags, result register
// depends on dbwu_pkg
module dbwu_datapath #(
    parameter int BP_SLOTS    = dbwu_pkg::BP_SLOTS_DEF,
    parameter int WATCH_SLOTS = dbwu_pkg::WATCH_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dbwu_pkg::item_t   item,
    input  logic              client_active,
    input  dbwu_pkg::dp_cmd_t cmd,
    output dbwu_pkg::result_t res
);
    import dbwu_pkg::*;

    item_t       item_reg;
    logic [63:0] end_reg;

    logic [63:0] bp_addr_reg [BP_SLOTS];
    logic [BP_SLOTS-1:0] bp_valid_reg;
    logic [63:0] rd_s_reg [WATCH_SLOTS];
    logic [63:0] rd_e_reg [WATCH_SLOTS];
    logic [1:0]  rd_k_reg [WATCH_SLOTS];
    logic [WATCH_SLOTS-1:0] rd_v_reg;
    logic [63:0] wr_s_reg [WATCH_SLOTS];
    logic [63:0] wr_e_reg [WATCH_SLOTS];
    logic [1:0]  wr_k_reg [WATCH_SLOTS];
    logic [WATCH_SLOTS-1:0] wr_v_reg;
    logic halt_forced_reg, halt_reported_reg, step_pending_reg, handshake_done_reg;
    result_t res_reg;

    // per-slot compare vectors, registered in the load stage
    logic [BP_SLOTS-1:0]    bp_eq_reg;
    logic [WATCH_SLOTS-1:0] rd_ov_reg, wr_ov_reg, rd_eq_reg, wr_eq_reg;
    logic [BP_SLOTS-1:0]    bp_eq_next;
    logic [WATCH_SLOTS-1:0] rd_ov_next, wr_ov_next, rd_eq_next, wr_eq_next;
    logic [63:0] end_next, aend_next;

    // range ends and per-slot compares on the incoming item
    always_comb
    begin
        end_next  = item.address + {32'd0, item.length} - 64'd1;
        aend_next = end_next;
        for (int i = 0; i < BP_SLOTS; i++)
        begin
            bp_eq_next[i] = bp_valid_reg[i] && (bp_addr_reg[i] == item.address);
        end
        for (int i = 0; i < WATCH_SLOTS; i++)
        begin
            rd_ov_next[i] = rd_v_reg[i] && (aend_next >= rd_s_reg[i])
                            && (item.address <= rd_e_reg[i]);
            wr_ov_next[i] = wr_v_reg[i] && (aend_next >= wr_s_reg[i])
                            && (item.address <= wr_e_reg[i]);
            rd_eq_next[i] = rd_v_reg[i] && (rd_s_reg[i] == item.address)
                            && (rd_e_reg[i] == end_next) && (rd_k_reg[i] == item.watch_kind);
            wr_eq_next[i] = wr_v_reg[i] && (wr_s_reg[i] == item.address)
                            && (wr_e_reg[i] == end_next) && (wr_k_reg[i] == item.watch_kind);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= item;
            end_reg   <= end_next;
            bp_eq_reg <= bp_eq_next;
            rd_ov_reg <= rd_ov_next;
            wr_ov_reg <= wr_ov_next;
            rd_eq_reg <= rd_eq_next;
            wr_eq_reg <= wr_eq_next;
        end
    end

    // lowest free slots and lowest hits
    logic                   bp_free_ok, rd_free_ok, wr_free_ok;
    logic [BP_SLOTS-1:0]    bp_free_oh;
    logic [WATCH_SLOTS-1:0] rd_free_oh, wr_free_oh;
    logic                   rd_hit, wr_hit;
    logic [1:0]             rd_hit_k, wr_hit_k;

    always_comb
    begin
        bp_free_oh = '0;
        bp_free_ok = 1'b0;
        for (int i = 0; i < BP_SLOTS; i++)
        begin
            if (!bp_valid_reg[i] && !bp_free_ok)
            begin
                bp_free_oh[i] = 1'b1;
                bp_free_ok    = 1'b1;
            end
        end
        rd_free_oh = '0;
        rd_free_ok = 1'b0;
        wr_free_oh = '0;
        wr_free_ok = 1'b0;
        rd_hit = 1'b0;
        wr_hit = 1'b0;
        rd_hit_k = '0;
        wr_hit_k = '0;
        for (int i = 0; i < WATCH_SLOTS; i++)
        begin
            if (!rd_v_reg[i] && !rd_free_ok)
            begin
                rd_free_oh[i] = 1'b1;
                rd_free_ok    = 1'b1;
            end
            if (!wr_v_reg[i] && !wr_free_ok)
            begin
                wr_free_oh[i] = 1'b1;
                wr_free_ok    = 1'b1;
            end
            if (rd_ov_reg[i] && !rd_hit)
            begin
                rd_hit   = 1'b1;
                rd_hit_k = rd_k_reg[i];
            end
            if (wr_ov_reg[i] && !wr_hit)
            begin
                wr_hit   = 1'b1;
                wr_hit_k = wr_k_reg[i];
            end
        end
    end

    // op execution: table writes, flag updates and result
    logic [BP_SLOTS-1:0]    bp_valid_next;
    logic [WATCH_SLOTS-1:0] rd_v_next, wr_v_next, rd_put, wr_put;
    logic bp_put;
    logic hf_next, hr_next, sp_next, hd_next;
    result_t res_next;
    logic        pc_hit;
    logic [1:0]  pc_n;
    logic        w_hit;
    logic [1:0]  w_k;

    always_comb
    begin
        bp_valid_next = bp_valid_reg;
        rd_v_next = rd_v_reg;
        wr_v_next = wr_v_reg;
        rd_put = '0;
        wr_put = '0;
        bp_put = 1'b0;
        hf_next = halt_forced_reg;
        hr_next = halt_reported_reg;
        sp_next = step_pending_reg;
        hd_next = handshake_done_reg;
        pc_hit = 1'b0;
        pc_n = '0;
        w_hit = 1'b0;
        w_k = '0;
        res_next = '{proceed: 1'b1, stop_notices: 2'd0, stop_signal: 8'd0,
                     stop_kind: SK_NONE, watch_address: 64'd0, table_full: 1'b0};
        unique case (item_reg.op)
            OP_SET_BP:
            begin
                if (bp_free_ok)
                begin
                    bp_put = 1'b1;
                    bp_valid_next = bp_valid_reg | bp_free_oh;
                end
                else
                begin
                    res_next.table_full = 1'b1;
                end
            end
            OP_CLR_BP:
            begin
                bp_valid_next = bp_valid_reg & ~bp_eq_reg;
            end
            OP_SET_WATCH:
            begin
                if (item_reg.watch_kind == WK_WRITE)
                begin
                    if (wr_free_ok) wr_put = wr_free_oh;
                    else res_next.table_full = 1'b1;
                end
                else if (item_reg.watch_kind == WK_READ)
                begin
                    if (rd_free_ok) rd_put = rd_free_oh;
                    else res_next.table_full = 1'b1;
                end
                else if (item_reg.watch_kind == WK_ACCESS)
                begin
                    if (rd_free_ok && wr_free_ok)
                    begin
                        rd_put = rd_free_oh;
                        wr_put = wr_free_oh;
                    end
                    else
                    begin
                        res_next.table_full = 1'b1;
                    end
                end
                rd_v_next = rd_v_reg | rd_put;
                wr_v_next = wr_v_reg | wr_put;
            end
            OP_CLR_WATCH:
            begin
                if (item_reg.watch_kind == WK_WRITE || item_reg.watch_kind == WK_ACCESS)
                    wr_v_next = wr_v_reg & ~wr_eq_reg;
                if (item_reg.watch_kind == WK_READ || item_reg.watch_kind == WK_ACCESS)
                    rd_v_next = rd_v_reg & ~rd_eq_reg;
            end
            OP_PC_CHECK:
            begin
                if (client_active)
                begin
                    pc_hit = (|bp_eq_reg) || halt_forced_reg;
                    if (pc_hit)
                    begin
                        hf_next = 1'b1;
                        if (!halt_reported_reg)
                        begin
                            hr_next = 1'b1;
                            pc_n = pc_n + 2'd1;
                        end
                    end
                    if (step_pending_reg)
                    begin
                        sp_next = 1'b0;
                        hf_next = 1'b1;
                        pc_n = pc_n + 2'd1;
                        pc_hit = 1'b1;
                    end
                    res_next.proceed = !pc_hit;
                    res_next.stop_notices = pc_n;
                    if (pc_n != 2'd0)
                    begin
                        res_next.stop_signal = SIG_TRAP;
                        res_next.stop_kind = SK_SIGNAL;
                    end
                end
            end
            OP_RD_CHECK, OP_WR_CHECK:
            begin
                w_hit = (item_reg.op == OP_RD_CHECK) ? rd_hit : wr_hit;
                w_k   = (item_reg.op == OP_RD_CHECK) ? rd_hit_k : wr_hit_k;
                if (client_active && w_hit)
                begin
                    hf_next = 1'b1;
                    hr_next = 1'b1;
                    res_next.proceed = 1'b0;
                    res_next.stop_notices = 2'd1;
                    res_next.stop_signal = SIG_TRAP;
                    res_next.stop_kind = SK_WATCH + {1'b0, w_k};
                    res_next.watch_address = item_reg.address;
                end
            end
            OP_HALT:
            begin
                hf_next = 1'b1;
                hr_next = 1'b0;
            end
            OP_CONTINUE:
            begin
                hd_next = 1'b1;
                hf_next = 1'b0;
                hr_next = 1'b0;
            end
            OP_STEP:
            begin
                sp_next = 1'b1;
                hf_next = 1'b0;
                hr_next = 1'b0;
            end
            OP_EXCEPTION:
            begin
                if (client_active && handshake_done_reg)
                begin
                    if (halt_forced_reg)
                    begin
                        res_next.proceed = 1'b0;
                    end
                    else
                    begin
                        hf_next = 1'b1;
                        hr_next = 1'b1;
                        res_next.stop_notices = 2'd1;
                        res_next.stop_signal = item_reg.signal_code;
                        res_next.stop_kind = SK_SIGNAL;
                    end
                end
            end
            OP_CLEAR_ALL:
            begin
                bp_valid_next = '0;
                rd_v_next = '0;
                wr_v_next = '0;
                hf_next = 1'b0;
                hr_next = 1'b0;
                sp_next = 1'b0;
                hd_next = 1'b0;
            end
            default:
            begin
                res_next.proceed = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_valid_reg <= '0;
            rd_v_reg <= '0;
            wr_v_reg <= '0;
            halt_forced_reg <= 1'b0;
            halt_reported_reg <= 1'b0;
            step_pending_reg <= 1'b0;
            handshake_done_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            bp_valid_reg <= bp_valid_next;
            rd_v_reg <= rd_v_next;
            wr_v_reg <= wr_v_next;
            halt_forced_reg <= hf_next;
            halt_reported_reg <= hr_next;
            step_pending_reg <= sp_next;
            handshake_done_reg <= hd_next;
        end
    end

    // table payload and result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            res_reg <= res_next;
            for (int i = 0; i < BP_SLOTS; i++)
            begin
                if (bp_put && bp_free_oh[i]) bp_addr_reg[i] <= item_reg.address;
            end
            for (int i = 0; i < WATCH_SLOTS; i++)
            begin
                if (rd_put[i])
                begin
                    rd_s_reg[i] <= item_reg.address;
                    rd_e_reg[i] <= end_reg;
                    rd_k_reg[i] <= item_reg.watch_kind;
                end
                if (wr_put[i])
                begin
                    wr_s_reg[i] <= item_reg.address;
                    wr_e_reg[i] <= end_reg;
                    wr_k_reg[i] <= item_reg.watch_kind;
                end
            end
        end
    end

    assign res = res_reg;

endmodule

### sv/dbwu_ctrl.sv
// controller of the debug unit: sequences load, execute and result strobe
// depends on dbwu_pkg
module dbwu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output dbwu_pkg::dp_cmd_t cmd
);
    import dbwu_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = start ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign cmd.load    = (state_reg == ST_IDLE) && start;
    assign cmd.execute = (state_reg == ST_EXEC);

endmodule

### sv/debug_breakpoint_watchpoint_unit.sv
// Debug breakpoint and watchpoint unit. An item is taken when start is high
// and busy is low; its result appears two cycles later for one cycle with
// result_valid high and cannot be held off, so the receiver must take it then.
// A new item is accepted the cycle after the result, giving one item every
// three cycles: one cycle registers all slot compares, one applies the op and
// registers the result, one presents it. client_active is written over its
// own valid/ready channel, ready whenever no item is in flight.
// depends on dbwu_pkg, dbwu_ctrl, dbwu_datapath
module debug_breakpoint_watchpoint_unit #(
    parameter int BP_SLOTS    = dbwu_pkg::BP_SLOTS_DEF,
    parameter int WATCH_SLOTS = dbwu_pkg::WATCH_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dbwu_pkg::item_t   item,
    output logic              result_valid,
    output dbwu_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import dbwu_pkg::*;

    dp_cmd_t cmd;
    logic    client_active_reg;

    // configuration register
    assign cfg_ready = !busy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) client_active_reg <= 1'b0;
        else if (cfg_valid && cfg_ready) client_active_reg <= cfg_data;
    end

    dbwu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (result_valid),
        .cmd   (cmd)
    );

    dbwu_datapath #(
        .BP_SLOTS    (BP_SLOTS),
        .WATCH_SLOTS (WATCH_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .client_active (client_active_reg),
        .cmd           (cmd),
        .res           (result)
    );

endmodule
